// ===== src/fts_pkg.sv =====
// Package for the formula token splitter: state and result types, codes and
// character class helpers shared by the step logic and the top level.
// No dependencies.
package fts_pkg;

  localparam logic [15:0] TabMax = 16'hFFFF;

  localparam logic [1:0] KIND_CONT = 2'd0;
  localparam logic [1:0] KIND_NEW  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  typedef struct packed {
    logic        in_quote;
    logic        in_comment;
    logic        held_dot;
    logic        held_bs;
    logic [15:0] tabs;
    logic [2:0]  tlen;
    logic [47:0] head;
    logic        all_dig;
    logic        dig_before;
    logic [7:0]  last_c;
    logic        prev_op;
  } st_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [15:0] rep;
    logic        last;
  } res_t;

  localparam st_t StReset = '{
    in_quote: 1'b0, in_comment: 1'b0, held_dot: 1'b0, held_bs: 1'b0,
    tabs: 16'd0, tlen: 3'd0, head: 48'd0, all_dig: 1'b1, dig_before: 1'b1,
    last_c: 8'd0, prev_op: 1'b0
  };

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // The head keeps the first character in the low byte, so the keyword
  // literals below are written back to front.
  function automatic logic ends_operand(input st_t s);
    logic [7:0] c0;
    c0 = s.head[7:0];
    if (s.tlen == 3'd1) begin
      return !(c0 == "(" || c0 == "," || c0 == "+" || c0 == "-" || c0 == "*" ||
               c0 == "/" || c0 == "%" || c0 == "^" || c0 == "=" || c0 == ">" ||
               c0 == "<" || c0 == "[" || c0 == "&");
    end
    if (s.tlen == 3'd2 && (s.head[15:0] == "==" || s.head[15:0] == "=!" ||
        s.head[15:0] == "=>" || s.head[15:0] == "=<" || s.head[15:0] == "fi")) begin
      return 1'b0;
    end
    if (s.tlen == 3'd4 && s.head[31:0] == "file") return 1'b0;
    if (s.tlen == 3'd5 && s.head[39:0] == "elihw") return 1'b0;
    if (s.tlen == 3'd6 && (s.head == "nruter" || s.head == "taeper")) return 1'b0;
    return 1'b1;
  endfunction

  function automatic st_t clear_tok(input st_t s);
    st_t r;
    r = s;
    r.tlen = 3'd0;
    r.head = 48'd0;
    r.all_dig = 1'b1;
    r.dig_before = 1'b1;
    r.last_c = 8'd0;
    return r;
  endfunction

  function automatic st_t flush_tok(input st_t s);
    st_t r;
    r = s;
    if (s.tlen != 3'd0) begin
      r.prev_op = ends_operand(s);
      r = clear_tok(r);
    end
    return r;
  endfunction

  function automatic st_t append_tok(input st_t s, input logic [7:0] c);
    st_t r;
    r = s;
    r.dig_before = s.all_dig;
    r.all_dig = s.all_dig && is_digit(c);
    if (s.tlen < 3'd6) r.head[s.tlen*8 +: 8] = c;
    r.last_c = c;
    if (s.tlen < 3'd7) r.tlen = s.tlen + 3'd1;
    return r;
  endfunction

endpackage

// ===== src/fts_if.sv =====
// Valid/ready channel interfaces for formula bytes and token characters.
// Depends on nothing.
interface fts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_formula;
  modport source (output valid, ch, end_of_formula, input ready);
  modport sink (input valid, ch, end_of_formula, output ready);
endinterface

interface fts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_char;
  logic [15:0] repeat_res;
  logic        last;
  modport source (output valid, kind, out_char, repeat_res, last, input ready);
  modport sink (input valid, kind, out_char, repeat_res, last, output ready);
endinterface

// ===== src/fts_step.sv =====
// Step logic: from the registered request and the current state, the results
// it causes and the next state. Depends on fts_pkg.
module fts_step
  import fts_pkg::*;
(
  input  st_t        st,
  input  logic [7:0] ch,
  input  logic       eof,
  output st_t        st_next,
  output res_t [3:0] res,
  output logic [2:0] cnt
);

  always_comb begin
    st_t        s;
    logic [2:0] n;
    logic       cv;
    logic [7:0] r;
    logic       nip;
    logic       pend;
    s = st;
    n = 3'd0;
    cv = 1'b1;
    r = ch;
    nip = 1'b0;
    pend = 1'b0;
    res = '0;
    if (eof) begin
      if (s.in_quote && s.held_bs) begin
        res[n[1:0]] = '{KIND_CONT, "\\", 16'd1, 1'b0}; n = n + 3'd1;
      end
      if (s.held_dot) begin
        res[n[1:0]] = '{KIND_NEW, ".", 16'd1, 1'b0}; n = n + 3'd1;
      end
      res[n[1:0]] = '{KIND_END, 8'd0, 16'd1, 1'b0}; n = n + 3'd1;
      s = StReset;
    end else if (s.in_comment) begin
      s = st;
    end else if (s.in_quote) begin
      if (ch == 8'd9) begin
        if (s.tabs != TabMax) s.tabs = s.tabs + 16'd1;
      end else if (s.held_bs && s.tabs == 16'd0) begin
        if (ch == "n") r = 8'd10;
        else if (ch == "t") r = 8'd9;
        res[n[1:0]] = '{KIND_CONT, r, 16'd1, 1'b0}; n = n + 3'd1;
        s.held_bs = 1'b0;
      end else begin
        if (s.tabs != 16'd0) begin
          res[n[1:0]] = '{KIND_CONT, 8'd9, s.tabs, 1'b0}; n = n + 3'd1;
          s.tabs = 16'd0;
          s.held_bs = 1'b0;
        end
        if (ch == "'") begin
          res[n[1:0]] = '{KIND_CONT, "'", 16'd1, 1'b0}; n = n + 3'd1;
          s.in_quote = 1'b0;
          s = clear_tok(s);
          s.prev_op = 1'b1;
        end else if (ch == "\\") begin
          s.held_bs = 1'b1;
        end else begin
          res[n[1:0]] = '{KIND_CONT, ch, 16'd1, 1'b0}; n = n + 3'd1;
        end
      end
    end else begin
      if (s.held_dot) begin
        s.held_dot = 1'b0;
        if (ch == ".") begin
          res[0] = '{KIND_NEW, " ", 16'd1, 1'b0};
          res[1] = '{KIND_CONT, ".", 16'd1, 1'b0};
          res[2] = '{KIND_CONT, ".", 16'd1, 1'b0};
          res[3] = '{KIND_CONT, " ", 16'd1, 1'b0};
          n = 3'd4;
          s.prev_op = 1'b0;
          cv = 1'b0;
        end else begin
          res[n[1:0]] = '{KIND_NEW, ".", 16'd1, 1'b0}; n = n + 3'd1;
          s.prev_op = 1'b1;
        end
      end
      if (cv) begin
        if (ch == "'") begin
          s = flush_tok(s);
          s.in_quote = 1'b1;
          res[n[1:0]] = '{KIND_NEW, "'", 16'd1, 1'b0}; n = n + 3'd1;
          s = append_tok(s, "'");
        end else if (ch == "(" || ch == ")" || ch == ",") begin
          s = flush_tok(s);
          res[n[1:0]] = '{KIND_NEW, ch, 16'd1, 1'b0}; n = n + 3'd1;
          s.prev_op = (ch == ")");
        end else if (ch == "#") begin
          s = flush_tok(s);
          s.in_comment = 1'b1;
        end else if (is_space(ch)) begin
          s = flush_tok(s);
        end else if (ch == ".") begin
          if (s.tlen != 3'd0 && s.all_dig) begin
            res[n[1:0]] = '{KIND_CONT, ch, 16'd1, 1'b0}; n = n + 3'd1;
            s = append_tok(s, ch);
          end else begin
            s = flush_tok(s);
            s.held_dot = 1'b1;
          end
        end else if (ch == "&" || ch == "*") begin
          if (s.tlen != 3'd0 && !is_ident(s.last_c)) s = flush_tok(s);
          if (s.tlen == 3'd0 && (ch == "&" || !s.prev_op)) begin
            res[n[1:0]] = '{KIND_NEW, ch, 16'd1, 1'b0}; n = n + 3'd1;
            s = append_tok(s, ch);
          end else if (ch == "*") begin
            s = flush_tok(s);
            res[n[1:0]] = '{KIND_NEW, ch, 16'd1, 1'b0}; n = n + 3'd1;
            s.prev_op = 1'b0;
          end else begin
            s = flush_tok(s);
            res[n[1:0]] = '{KIND_NEW, ch, 16'd1, 1'b0}; n = n + 3'd1;
            s = append_tok(s, ch);
          end
        end else if (ch == "+" || ch == "-" || ch == "/" || ch == "%") begin
          s = flush_tok(s);
          res[n[1:0]] = '{KIND_NEW, ch, 16'd1, 1'b0}; n = n + 3'd1;
          s.prev_op = 1'b0;
        end else if (is_ident(ch)) begin
          nip = s.tlen >= 3'd2 && s.last_c == "." && s.dig_before;
          pend = s.tlen == 3'd1 && (s.head[7:0] == "*" || s.head[7:0] == "&");
          if (s.tlen != 3'd0 && !is_ident(s.last_c) && !nip && !pend) s = flush_tok(s);
          res[n[1:0]] = '{(s.tlen == 3'd0) ? KIND_NEW : KIND_CONT, ch, 16'd1, 1'b0};
          n = n + 3'd1;
          s = append_tok(s, ch);
        end else begin
          if (s.tlen != 3'd0 && is_ident(s.last_c)) s = flush_tok(s);
          res[n[1:0]] = '{(s.tlen == 3'd0) ? KIND_NEW : KIND_CONT, ch, 16'd1, 1'b0};
          n = n + 3'd1;
          s = append_tok(s, ch);
        end
      end
    end
    if (n != 3'd0) res[n[1:0] - 2'd1].last = 1'b1;
    st_next = s;
    cnt = n;
  end

endmodule

// ===== src/formula_token_splitter.sv =====
// Top level of the formula token splitter: request register, token state,
// result bank and output channel. Depends on fts_pkg, fts_if and fts_step.
//
//   channel   direction  carries
//   formula   sink       ch, end_of_formula
//   tokens    source     kind, out_char, repeat_res, last
//
// A request enters a register, is worked by the combinational step logic
// and loads up to four results into a bank that drains one result per cycle
// while tokens is ready; a request can load as the last result drains.
// Synchronous reset empties the bank and returns the token state to idle.
// A stalled tokens channel holds the bank and then the request register.
module formula_token_splitter
  import fts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  fts_in_if.sink    formula,
  fts_out_if.source tokens
);

  logic       ir_valid;
  logic [7:0] ir_ch;
  logic       ir_eof;
  st_t        st;
  st_t        st_next;
  res_t [3:0] step_res;
  logic [2:0] step_cnt;
  res_t [3:0] bank;
  logic [2:0] rem;
  logic [1:0] idx;
  logic       bank_free;
  logic       load;

  fts_step u_step (
    .st      (st),
    .ch      (ir_ch),
    .eof     (ir_eof),
    .st_next (st_next),
    .res     (step_res),
    .cnt     (step_cnt)
  );

  assign bank_free = (rem == 3'd0) || (rem == 3'd1 && tokens.ready);
  assign load = ir_valid && bank_free;
  assign formula.ready = !ir_valid || load;

  assign tokens.valid = rem != 3'd0;
  assign tokens.kind = bank[idx].kind;
  assign tokens.out_char = bank[idx].ch;
  assign tokens.repeat_res = bank[idx].rep;
  assign tokens.last = bank[idx].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (formula.valid && formula.ready) begin
      ir_valid <= 1'b1;
    end else if (load) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (formula.valid && formula.ready) begin
      ir_ch <= formula.ch;
      ir_eof <= formula.end_of_formula;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= StReset;
      rem <= 3'd0;
      idx <= 2'd0;
    end else if (load) begin
      st <= st_next;
      rem <= step_cnt;
      idx <= 2'd0;
    end else if (tokens.valid && tokens.ready) begin
      rem <= rem - 3'd1;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bank <= step_res;
    end
  end

endmodule

// ===== test/fts_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench copy note: the channel interfaces live with the RTL in src/fts_if.sv.
// This file holds the request record type used by the testbench; depends on nothing.
package fts_tb_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       eof;
  } req_t;

endpackage

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for formula_token_splitter: drives formula bytes, predicts the token
// characters with its own model of the splitter and checks every result.
// Depends on fts_pkg, fts_if, fts_tb_pkg and the RTL.
module testbench;
  import fts_pkg::*;
  import fts_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  fts_in_if formula ();
  fts_out_if tokens ();

  formula_token_splitter u_top (.clk(clk), .rst(rst), .formula(formula), .tokens(tokens));

  always #1 clk = ~clk;

  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_cycles = 0;
  int hold_req = 0;
  int hold_seen = 0;
  res_t token_queue[$];

  // Splitter state kept by the predictor.
  logic        p_quote, p_comment, p_dot, p_bs;
  logic [15:0] p_tabs;
  logic [2:0]  p_len;
  logic [47:0] p_head;
  logic        p_alldig, p_digbefore;
  logic [7:0]  p_lastc;
  logic        p_prevop;
  res_t        step_res[$];

  function automatic logic dig(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic word_ch(input logic [7:0] c);
    return dig(c) || (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90) || c == 8'd95;
  endfunction

  function automatic logic head_eq(input string s);
    if (p_len != s.len()) return 1'b0;
    for (int i = 0; i < s.len(); i++) begin
      if (p_head[i*8 +: 8] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic closes_operand();
    logic [7:0] c0;
    c0 = p_head[7:0];
    if (p_len == 3'd1) begin
      return !(c0 inside {"(", ",", "+", "-", "*", "/", "%", "^", "=", ">", "<", "[", "&"});
    end
    if (head_eq("==") || head_eq("!=") || head_eq(">=") || head_eq("<=") || head_eq("if") ||
        head_eq("elif") || head_eq("while") || head_eq("return") || head_eq("repeat")) begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic put(input logic [1:0] k, input logic [7:0] c, input logic [15:0] r);
    res_t x;
    x.kind = k;
    x.ch = c;
    x.rep = r;
    x.last = 1'b0;
    step_res.insert(step_res.size(), x);
  endtask

  task automatic tok_clear();
    p_len = 3'd0;
    p_head = '0;
    p_alldig = 1'b1;
    p_digbefore = 1'b1;
    p_lastc = 8'd0;
  endtask

  task automatic splitter_reset();
    p_quote = 1'b0;
    p_comment = 1'b0;
    p_dot = 1'b0;
    p_bs = 1'b0;
    p_tabs = 16'd0;
    p_prevop = 1'b0;
    tok_clear();
  endtask

  task automatic tok_flush();
    if (p_len != 0) begin
      p_prevop = closes_operand();
      tok_clear();
    end
  endtask

  task automatic tok_add(input logic [7:0] c);
    put(p_len == 0 ? KIND_NEW : KIND_CONT, c, 16'd1);
    p_digbefore = p_alldig;
    p_alldig = p_alldig && dig(c);
    if (p_len < 3'd6) p_head[p_len*8 +: 8] = c;
    p_lastc = c;
    if (p_len < 3'd7) p_len = p_len + 3'd1;
  endtask

  task automatic quoted(input logic [7:0] c);
    logic [7:0] r;
    if (c == 8'd9) begin
      if (p_tabs != TabMax) p_tabs++;
      return;
    end
    if (p_bs && p_tabs == 0) begin
      r = (c == "n") ? 8'd10 : (c == "t") ? 8'd9 : c;
      put(KIND_CONT, r, 16'd1);
      p_bs = 1'b0;
      return;
    end
    if (p_tabs != 0) begin
      put(KIND_CONT, 8'd9, p_tabs);
      p_tabs = 16'd0;
      p_bs = 1'b0;
    end
    if (c == "'") begin
      put(KIND_CONT, c, 16'd1);
      p_quote = 1'b0;
      tok_clear();
      p_prevop = 1'b1;
    end else if (c == "\\") begin
      p_bs = 1'b1;
    end else begin
      put(KIND_CONT, c, 16'd1);
    end
  endtask

  task automatic unquoted(input logic [7:0] c);
    logic numrun, pend;
    if (c == "'") begin
      tok_flush();
      p_quote = 1'b1;
      tok_add(c);
      return;
    end
    if (c == "(" || c == ")" || c == ",") begin
      tok_flush();
      put(KIND_NEW, c, 16'd1);
      p_prevop = (c == ")");
      return;
    end
    if (c == "#") begin
      tok_flush();
      p_comment = 1'b1;
      return;
    end
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
      tok_flush();
      return;
    end
    if (c == ".") begin
      if (p_len != 0 && p_alldig) begin
        tok_add(c);
      end else begin
        tok_flush();
        p_dot = 1'b1;
      end
      return;
    end
    if (c == "&" || c == "*") begin
      if (p_len != 0 && !word_ch(p_lastc)) tok_flush();
      if (p_len == 0 && (c == "&" || !p_prevop)) begin
        tok_add(c);
        return;
      end
    end
    if (c inside {"+", "-", "*", "/", "%"}) begin
      tok_flush();
      put(KIND_NEW, c, 16'd1);
      p_prevop = 1'b0;
      return;
    end
    if (word_ch(c)) begin
      numrun = p_len >= 2 && p_lastc == "." && p_digbefore;
      pend = p_len == 1 && (p_head[7:0] == "*" || p_head[7:0] == "&");
      if (p_len != 0 && !word_ch(p_lastc) && !numrun && !pend) tok_flush();
      tok_add(c);
      return;
    end
    if (p_len != 0 && word_ch(p_lastc)) tok_flush();
    tok_add(c);
  endtask

  task automatic predict_step(input req_t q);
    step_res.delete();
    if (q.eof) begin
      if (p_quote && p_bs) put(KIND_CONT, "\\", 16'd1);
      if (p_dot) put(KIND_NEW, ".", 16'd1);
      put(KIND_END, 8'd0, 16'd1);
      splitter_reset();
    end else if (p_comment) begin
    end else if (p_quote) begin
      quoted(q.ch);
    end else begin
      if (p_dot) begin
        p_dot = 1'b0;
        if (q.ch == ".") begin
          put(KIND_NEW, " ", 16'd1);
          put(KIND_CONT, ".", 16'd1);
          put(KIND_CONT, ".", 16'd1);
          put(KIND_CONT, " ", 16'd1);
          p_prevop = 1'b0;
        end else begin
          put(KIND_NEW, ".", 16'd1);
          p_prevop = 1'b1;
        end
      end
      if (!(q.ch == "." && step_res.size() == 4)) unquoted(q.ch);
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
    foreach (step_res[i]) token_queue.insert(token_queue.size(), step_res[i]);
  endtask

  // Sends one request; the prediction is made when it is accepted.
  task automatic send_byte(input logic [7:0] c, input logic eof);
    req_t q;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      formula.valid <= 1'b0;
      @(negedge clk);
    end
    formula.valid <= 1'b1;
    formula.ch <= c;
    formula.end_of_formula <= eof;
    q.ch = c;
    q.eof = eof;
    @(posedge clk);
    while (!formula.ready) @(posedge clk);
    predict_step(q);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    send_byte(8'd0, 1'b1);
  endtask

  task automatic drain();
    formula.valid <= 1'b0;
    while (token_queue.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      tokens.ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_cycles <= 60;
      tokens.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      tokens.ready <= 1'b0;
    end else begin
      tokens.ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && tokens.valid && tokens.ready) begin
      if (token_queue.size() == 0) begin
        $display("%0t unexpected result kind=%0d char=%h rep=%0d last=%0d", $time,
                 tokens.kind, tokens.out_char, tokens.repeat_res, tokens.last);
        errors++;
      end else begin
        want = token_queue.pop_front();
        if (want.kind !== tokens.kind || want.ch !== tokens.out_char ||
            want.rep !== tokens.repeat_res || want.last !== tokens.last) begin
          $display("%0t mismatch expected kind=%0d char=%h rep=%0d last=%0d",
                   $time, want.kind, want.ch, want.rep, want.last);
          $display("%0t          actual   kind=%0d char=%h rep=%0d last=%0d",
                   $time, tokens.kind, tokens.out_char, tokens.repeat_res, tokens.last);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_text("x=(a+b)*2.5..'s\\n\\q'");
    send_text("return *p&q while -1 # note");
    send_text("'ab\t\tc\t\t'");
    send_text("'x\\\t\t");
    send_text("'y\\");
    send_text(". .a 12.3.4");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  function automatic logic [7:0] pick_char();
    string pool;
    pool = "abz_09.'\\\t #()*&,+-/%=<>!^[ ne";
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  task automatic test_random(input int n);
    int count;
    count = 0;
    while (count < n) begin
      if ($urandom_range(7) == 0) begin
        send_byte(pick_char(), 1'b1);
      end else begin
        send_byte(pick_char(), 1'b0);
      end
      count++;
    end
    send_byte(8'd0, 1'b1);
  endtask

  task automatic test_backpressure();
    hold_req = hold_req + 1;
    for (int i = 0; i < 12; i++) send_byte(".", 1'b0);
    send_byte(8'd0, 1'b1);
  endtask

  initial begin
    formula.valid = 1'b0;
    formula.ch = 8'd0;
    formula.end_of_formula = 1'b0;
    splitter_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(18);
    send_idle = 66;
    test_random(18);
    send_idle = 0;
    recv_stall = 66;
    test_random(18);
    send_idle = 18;
    recv_stall = 18;
    test_random(18);
    send_idle = 0;
    recv_stall = 0;
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("PASS formula_token_splitter");
    end else begin
      $display("FAIL formula_token_splitter");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL formula_token_splitter");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/fts_pkg.sv
src/fts_if.sv
src/fts_step.sv
src/formula_token_splitter.sv
test/fts_tb_if.sv
test/testbench.sv
